[hw/rtl/dstq_pkg.sv]
// Package for the deadline sorted task queue.
// Holds the item structs, action and status codes, and sizing constants.
// No dependencies.
package dstq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TOTAL_W     = 5;
    localparam int FIFO_DEPTH  = 2;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_POP,
        OP_REMOVE,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  task_id;
        logic [31:0] sort_key;
    } req_t;

    typedef struct packed {
        logic [7:0]         out_task_id;
        logic [31:0]        out_key;
        logic [1:0]         status;
        logic [TOTAL_W-1:0] entry_total;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [31:0] sort_key;
    } entry_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  task_id;
        logic [31:0] sort_key;
    } cmd_t;

    function automatic logic [TOTAL_W-1:0] to_total(input logic [CNT_W-1:0] c);
        return TOTAL_W'(c);
    endfunction

endpackage

[hw/rtl/dstq_front.sv]
// Front end: accepts request items, decodes the action and buffers
// decoded commands in a two-entry queue. Depends on dstq_pkg.
module dstq_front
    import dstq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic cmd_valid,
    input  logic cmd_take,
    output cmd_t cmd
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t              slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;
    cmd_t              decoded;
    logic              push;

    always_comb
    begin
        decoded.task_id  = req.task_id;
        decoded.sort_key = req.sort_key;
        unique case (req.action)
            ACT_INSERT: decoded.op = OP_INSERT;
            ACT_POP:    decoded.op = OP_POP;
            ACT_REMOVE: decoded.op = OP_REMOVE;
            default:    decoded.op = OP_NOP;
        endcase
    end

    assign req_stall = (fcnt_reg == FCNT_W'(FIFO_DEPTH));
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (fcnt_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = cmd_take ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fcnt_next   = fcnt_reg;
        if (push && !cmd_take)
        begin
            fcnt_next = FCNT_W'(fcnt_reg + 1'b1);
        end
        else if (!push && cmd_take)
        begin
            fcnt_next = FCNT_W'(fcnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fcnt_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fcnt_reg   <= fcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

[hw/rtl/dstq_back.sv]
// Back end: sorted shift-register cell array with a comparator per cell.
// One command per cycle into a registered result unless stalled; uses dstq_pkg.
module dstq_back
    import dstq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_take,
    input  cmd_t             cmd,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp,
    output logic [CNT_W-1:0] cnt
);

    entry_t                 cell_reg  [QUEUE_DEPTH];
    entry_t                 cell_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]       count_reg, count_next;
    rsp_t                   rsp_reg, rsp_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [QUEUE_DEPTH-1:0] live, lt, match, hit_upto, first_oh, ins_oh;
    entry_t                 sel;
    logic                   found, full, empty, fire;

    assign fire      = cmd_valid && (!rsp_valid_reg || !rsp_stall);
    assign cmd_take  = fire;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cnt       = count_reg;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            live[i]  = CNT_W'(i) < count_reg;
            lt[i]    = live[i] && (cell_reg[i].sort_key < cmd.sort_key);
            match[i] = live[i] && (cell_reg[i].task_id == cmd.task_id);
        end
        hit_upto[0] = match[0];
        ins_oh[0]   = !lt[0];
        for (int i = 1; i < QUEUE_DEPTH; i++)
        begin
            hit_upto[i] = hit_upto[i-1] | match[i];
            ins_oh[i]   = !lt[i] && lt[i-1];
        end
        found    = hit_upto[QUEUE_DEPTH-1];
        first_oh = match & ~(hit_upto << 1);
        sel      = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            sel = sel | (first_oh[i] ? cell_reg[i] : entry_t'('0));
        end
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        count_next           = count_reg;
        rsp_next.out_task_id = '0;
        rsp_next.out_key     = '0;
        rsp_next.status      = ST_MISS;
        rsp_next.entry_total = to_total(count_reg);
        unique case (cmd.op)
            OP_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    if (ins_oh[0])
                    begin
                        cell_next[0].task_id  = cmd.task_id;
                        cell_next[0].sort_key = cmd.sort_key;
                    end
                    for (int i = 1; i < QUEUE_DEPTH; i++)
                    begin
                        if (ins_oh[i])
                        begin
                            cell_next[i].task_id  = cmd.task_id;
                            cell_next[i].sort_key = cmd.sort_key;
                        end
                        else if (!lt[i])
                        begin
                            cell_next[i] = cell_reg[i-1];
                        end
                    end
                    count_next           = CNT_W'(count_reg + 1'b1);
                    rsp_next.out_task_id = cmd.task_id;
                    rsp_next.out_key     = cmd.sort_key;
                    rsp_next.status      = ST_DONE;
                    rsp_next.entry_total = to_total(count_next);
                end
            end
            OP_POP:
            begin
                if (!empty)
                begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    begin
                        cell_next[i] = cell_reg[i+1];
                    end
                    count_next           = CNT_W'(count_reg - 1'b1);
                    rsp_next.out_task_id = cell_reg[0].task_id;
                    rsp_next.out_key     = cell_reg[0].sort_key;
                    rsp_next.status      = ST_DONE;
                    rsp_next.entry_total = to_total(count_next);
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    begin
                        if (hit_upto[i])
                        begin
                            cell_next[i] = cell_reg[i+1];
                        end
                    end
                    count_next           = CNT_W'(count_reg - 1'b1);
                    rsp_next.out_task_id = sel.task_id;
                    rsp_next.out_key     = sel.sort_key;
                    rsp_next.status      = ST_DONE;
                    rsp_next.entry_total = to_total(count_next);
                end
            end
            OP_NOP:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

endmodule

[hw/rtl/deadline_sorted_task_queue.sv]
// Top level of the deadline sorted task queue.
// Joins dstq_front and dstq_back; depends on dstq_pkg.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (req_t)
//   result  | rsp_valid | rsp_stall | rsp (rsp_t)
//
// One item per cycle sustained while rsp_stall is low; each accepted request
// passes through the command buffer, then through the cell array's
// insert/remove step into the result register.
// Reset empties the queue and the command buffer at once; no clearing pass.
// Result stall holds the result register; the two-entry command buffer then
// fills and raises req_stall.
module deadline_sorted_task_queue
    import dstq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic             cmd_valid;
    logic             cmd_take;
    cmd_t             cmd;
    logic [CNT_W-1:0] cnt;

    dstq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    dstq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cnt       (cnt)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.entry_total == TOTAL_W'(QUEUE_DEPTH))
        else $error("full status with queue not full");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_DONE |-> rsp.out_task_id == '0 && rsp.out_key == '0)
        else $error("failed action reports nonzero entry");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !rsp_valid |=> rsp_valid)
        else $error("pending command not executed");

endmodule
